>>> rtl/sha_pkg.sv
// shared types, constants and round functions for the sha-256 digest unit
package sha_pkg;

	localparam int unsigned WordWidth = 32;
	localparam int unsigned NumRounds = 64;
	localparam int unsigned CountWidth = 61;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_COMPRESS,
		ST_ADD,
		ST_PAD,
		ST_EMIT
	} state_t;

	// commands from controller to datapath
	typedef struct packed {
		logic take_byte;     // write input byte into block buffer, bump count
		logic start_block;   // load round vars from chaining value
		logic do_round;      // run one compression round
		logic add_chain;     // fold round vars into chaining value
		logic pad_first;     // write 0x80 and zeros after the tail
		logic pad_length;    // write bit length into the last two buffer words
		logic clear_all;     // clear buffer before the length when in extra block
		logic reset_msg;     // restore initial hash and count
	} dp_cmd_t;

	// status from datapath to controller
	typedef struct packed {
		logic block_full;    // the byte now being taken fills the block
		logic tail_high;     // tail position is 56 or more
	} dp_status_t;

	localparam logic [WordWidth-1:0] InitHash [8] = '{
		32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
		32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
	};

	localparam logic [WordWidth-1:0] RoundK [NumRounds] = '{
		32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
		32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
		32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
		32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
		32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
		32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
		32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
		32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
		32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
		32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
		32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
		32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
		32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
		32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
		32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
		32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
	};

	function automatic logic [WordWidth-1:0] ror(input logic [WordWidth-1:0] x,
			input int unsigned n);
		return (x >> n) | (x << (WordWidth - n));
	endfunction

endpackage

>>> rtl/sha_ctrl.sv
// controller state machine sequencing byte intake, rounds, padding and output
module sha_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  logic                byte_present,
	input  logic                end_of_message,
	output logic                out_valid,
	input  logic                out_ready,
	output logic [2:0]          word_index,
	output logic                last_word,
	input  sha_pkg::dp_status_t status,
	output sha_pkg::dp_cmd_t    cmd,
	output logic [5:0]          round_idx
);

	sha_pkg::state_t state_q, state_d;
	logic [5:0] round_q;
	logic [2:0] word_q;
	logic       end_q;      // message ends once the current block is done
	logic       pad_done_q; // padding with length is in the buffer
	logic       pad_extra_q;// first pad block is done, length block still due
	logic       accept;

	assign accept = in_valid && (state_q == sha_pkg::ST_IDLE);
	assign round_idx = round_q;
	assign word_index = word_q;
	assign last_word = (word_q == 3'd7);

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			sha_pkg::ST_IDLE: begin
				if (accept) begin
					if (byte_present && status.block_full) begin
						state_d = sha_pkg::ST_COMPRESS;
					end else if (end_of_message) begin
						state_d = sha_pkg::ST_PAD;
					end
				end
			end
			sha_pkg::ST_COMPRESS: begin
				if (round_q == 6'd63) begin
					state_d = sha_pkg::ST_ADD;
				end
			end
			sha_pkg::ST_ADD: begin
				priority if (pad_done_q) begin
					state_d = sha_pkg::ST_EMIT;
				end else if (end_q) begin
					state_d = sha_pkg::ST_PAD;
				end else begin
					state_d = sha_pkg::ST_IDLE;
				end
			end
			sha_pkg::ST_PAD: begin
				state_d = sha_pkg::ST_COMPRESS;
			end
			sha_pkg::ST_EMIT: begin
				if (out_ready && word_q == 3'd7) begin
					state_d = sha_pkg::ST_IDLE;
				end
			end
			default: state_d = sha_pkg::ST_IDLE;
		endcase
	end

	// outputs and datapath commands
	always_comb begin
		cmd = '0;
		in_ready = 1'b0;
		out_valid = 1'b0;
		unique case (state_q)
			sha_pkg::ST_IDLE: begin
				in_ready = 1'b1;
				cmd.take_byte = in_valid && byte_present;
				cmd.start_block = in_valid && byte_present && status.block_full;
			end
			sha_pkg::ST_COMPRESS: begin
				cmd.do_round = 1'b1;
			end
			sha_pkg::ST_ADD: begin
				cmd.add_chain = 1'b1;
			end
			sha_pkg::ST_PAD: begin
				cmd.start_block = 1'b1;
				cmd.pad_first = !pad_extra_q;
				cmd.clear_all = pad_extra_q;
				cmd.pad_length = pad_extra_q || !status.tail_high;
			end
			sha_pkg::ST_EMIT: begin
				out_valid = 1'b1;
				cmd.reset_msg = out_ready && word_q == 3'd7;
			end
			default: ;
		endcase
	end

	// state and counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= sha_pkg::ST_IDLE;
			round_q <= '0;
			word_q <= '0;
			end_q <= 1'b0;
			pad_done_q <= 1'b0;
			pad_extra_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == sha_pkg::ST_COMPRESS) begin
				round_q <= round_q + 6'd1;
			end else begin
				round_q <= '0;
			end
			if (accept) begin
				end_q <= end_of_message;
			end
			if (state_q == sha_pkg::ST_PAD) begin
				if (pad_extra_q || !status.tail_high) begin
					pad_done_q <= 1'b1;
				end else begin
					pad_extra_q <= 1'b1;
				end
			end
			if (state_q == sha_pkg::ST_EMIT && out_ready) begin
				word_q <= word_q + 3'd1;
				if (word_q == 3'd7) begin
					end_q <= 1'b0;
					pad_done_q <= 1'b0;
					pad_extra_q <= 1'b0;
				end
			end
		end
	end

endmodule

>>> rtl/sha_datapath.sv
// block buffer, message schedule, round logic and chaining value
module sha_datapath (
	input  logic                 clk,
	input  logic                 arst_n,
	input  sha_pkg::dp_cmd_t     cmd,
	input  logic [5:0]           round_idx,
	input  logic [7:0]           msg_byte,
	input  logic [2:0]           word_index,
	output sha_pkg::dp_status_t  status,
	output logic [31:0]          digest_word
);

	logic [31:0] buf_q [16];
	logic [31:0] w_q [16];
	logic [31:0] v_q [8];
	logic [31:0] h_q [8];
	logic [sha_pkg::CountWidth-1:0] count_q;
	logic [5:0]  tail;
	logic [63:0] bits;
	logic [31:0] w_new, t1, t2, x2, x15, s0, s1;

	assign tail = count_q[5:0];
	assign bits = {count_q, 3'b000};
	assign status.block_full = (tail == 6'd63);
	assign status.tail_high = (tail >= 6'd56);
	assign digest_word = h_q[word_index];

	// schedule word and round terms; window shifts so w_q[0] is oldest
	always_comb begin
		x2 = w_q[14];
		x15 = w_q[1];
		s1 = sha_pkg::ror(x2, 17) ^ sha_pkg::ror(x2, 19) ^ (x2 >> 10);
		s0 = sha_pkg::ror(x15, 7) ^ sha_pkg::ror(x15, 18) ^ (x15 >> 3);
		if (round_idx < 6'd16) begin
			w_new = buf_q[round_idx[3:0]];
		end else begin
			w_new = s1 + w_q[9] + s0 + w_q[0];
		end
		t1 = v_q[7] + (sha_pkg::ror(v_q[4], 6) ^ sha_pkg::ror(v_q[4], 11)
			^ sha_pkg::ror(v_q[4], 25)) + ((v_q[4] & v_q[5]) ^ (~v_q[4] & v_q[6]))
			+ sha_pkg::RoundK[round_idx] + w_new;
		t2 = (sha_pkg::ror(v_q[0], 2) ^ sha_pkg::ror(v_q[0], 13) ^ sha_pkg::ror(v_q[0], 22))
			+ ((v_q[0] & v_q[1]) ^ (v_q[0] & v_q[2]) ^ (v_q[1] & v_q[2]));
	end

	// byte count and chaining value
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			for (int i = 0; i < 8; i++) begin
				h_q[i] <= sha_pkg::InitHash[i];
			end
		end else begin
			if (cmd.take_byte) begin
				count_q <= count_q + {{(sha_pkg::CountWidth-1){1'b0}}, 1'b1};
			end
			if (cmd.add_chain) begin
				for (int i = 0; i < 8; i++) begin
					h_q[i] <= h_q[i] + v_q[i];
				end
			end
			if (cmd.reset_msg) begin
				count_q <= '0;
				for (int i = 0; i < 8; i++) begin
					h_q[i] <= sha_pkg::InitHash[i];
				end
			end
		end
	end

	// block buffer writes and padding, four bytes per word, first byte on top
	always_ff @(posedge clk) begin
		if (cmd.take_byte) begin
			buf_q[tail[5:2]][{~tail[1:0], 3'b000} +: 8] <= msg_byte;
		end
		for (int i = 0; i < 16; i++) begin
			if (cmd.pad_length && i >= 14) begin
				buf_q[i] <= (i == 14) ? bits[63:32] : bits[31:0];
			end else if (cmd.clear_all) begin
				buf_q[i] <= '0;
			end else if (cmd.pad_first) begin
				for (int j = 0; j < 4; j++) begin
					if (6'(4*i + j) == tail) begin
						buf_q[i][8*(3-j) +: 8] <= 8'h80;
					end else if (6'(4*i + j) > tail) begin
						buf_q[i][8*(3-j) +: 8] <= 8'h00;
					end
				end
			end
		end
	end

	// schedule window and working variables
	always_ff @(posedge clk) begin
		if (cmd.start_block) begin
			for (int i = 0; i < 8; i++) begin
				v_q[i] <= h_q[i];
			end
		end
		if (cmd.do_round) begin
			if (round_idx < 6'd16) begin
				w_q[round_idx[3:0]] <= w_new;
			end else begin
				for (int i = 0; i < 15; i++) begin
					w_q[i] <= w_q[i+1];
				end
				w_q[15] <= w_new;
			end
			v_q[7] <= v_q[6];
			v_q[6] <= v_q[5];
			v_q[5] <= v_q[4];
			v_q[4] <= v_q[3] + t1;
			v_q[3] <= v_q[2];
			v_q[2] <= v_q[1];
			v_q[1] <= v_q[0];
			v_q[0] <= t1 + t2;
		end
	end

endmodule

>>> rtl/sha256_message_digest_unit.sv
// top level of the sha-256 digest unit
// Takes one message byte per transaction and hashes it with SHA-256. A byte that
// does not finish a 64-byte block is written into the block buffer; the byte that
// finishes it starts a compression of the block and then a chaining add, during
// which input is held off. Ending a message adds a padding step, a compression
// and a chaining add, twice when the tail is 56 bytes or more, then eight digest
// words are offered in order, one per cycle while the sink is ready, before the
// next message is taken.
module sha256_message_digest_unit (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [7:0]  msg_byte,
	input  logic        byte_present,
	input  logic        end_of_message,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [31:0] digest_word,
	output logic [2:0]  word_index,
	output logic        last_word
);

	sha_pkg::dp_cmd_t    cmd;
	sha_pkg::dp_status_t status;
	logic [5:0]          round_idx;

	sha_ctrl u_ctrl (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_ready       (in_ready),
		.byte_present   (byte_present),
		.end_of_message (end_of_message),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.word_index     (word_index),
		.last_word      (last_word),
		.status         (status),
		.cmd            (cmd),
		.round_idx      (round_idx)
	);

	sha_datapath u_datapath (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.round_idx   (round_idx),
		.msg_byte    (msg_byte),
		.word_index  (word_index),
		.status      (status),
		.digest_word (digest_word)
	);

endmodule
